### sv/mcsp_pkg.sv
// Shared constants, state codes and bus structs for the memory card serial protocol block.
package mcsp_pkg;

    localparam int SECTOR_COUNT = 1024;
    localparam int SECTOR_BYTES = 128;
    localparam int STORE_BYTES  = SECTOR_COUNT * SECTOR_BYTES;
    localparam int SEC_W        = $clog2(SECTOR_COUNT);
    localparam int CNT_W        = $clog2(SECTOR_BYTES);
    localparam int ADDR_W       = $clog2(STORE_BYTES);

    localparam logic [7:0] BYTE_SELECT  = 8'h81;
    localparam logic [7:0] BYTE_READ    = 8'h52;
    localparam logic [7:0] BYTE_WRITE   = 8'h57;
    localparam logic [7:0] BYTE_ID1     = 8'h5A;
    localparam logic [7:0] BYTE_ID2     = 8'h5D;
    localparam logic [7:0] BYTE_CMD_ACK = 8'h5C;
    localparam logic [7:0] BYTE_END     = 8'h47;
    localparam logic [7:0] BYTE_IDLE    = 8'hFF;
    localparam logic [7:0] FLAGS_RESET  = 8'h08;
    localparam logic [7:0] FLAGS_WRMASK = 8'hF7;
    localparam logic [15:0] ADDR_MASK   = 16'h03FF;
    localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(SECTOR_BYTES - 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CMD,
        ST_R_ID1, ST_R_ID2, ST_R_A1, ST_R_A2, ST_R_ACK1, ST_R_ACK2,
        ST_R_CA1, ST_R_CA2, ST_R_DATA, ST_R_CHK, ST_R_END,
        ST_W_ID1, ST_W_ID2, ST_W_A1, ST_W_A2, ST_W_DATA, ST_W_CHK,
        ST_W_ACK1, ST_W_ACK2, ST_W_END
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    typedef struct packed {
        logic       ack;
        logic [7:0] rx_byte;
    } t_result;

endpackage

### sv/mcsp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module mcsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mcsp_fsm.sv
// Protocol sequencer: state, address, count, checksum and flags; drives the card store ports.
module mcsp_fsm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic                         i_kind,
    input  logic [7:0]                   i_tx_byte,
    input  logic [7:0]                   i_rd_data,
    output logic [mcsp_pkg::ADDR_W-1:0]  o_rd_addr,
    output mcsp_pkg::t_ram_wr            o_wr,
    output mcsp_pkg::t_result            o_result
);

    mcsp_pkg::t_state r_state, n_state;
    logic [15:0]                r_sector_addr, n_sector_addr;
    logic [mcsp_pkg::CNT_W-1:0] r_byte_count, n_byte_count;
    logic [7:0]                 r_running_xor, n_running_xor;
    logic [7:0]                 r_card_flags, n_card_flags;
    logic [7:0]                 r_prev_tx, n_prev_tx;

    logic [15:0] low_latched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mcsp_pkg::ST_IDLE;
            r_sector_addr <= '0;
            r_byte_count  <= '0;
            r_running_xor <= '0;
            r_card_flags  <= mcsp_pkg::FLAGS_RESET;
            r_prev_tx     <= '0;
        end else begin
            r_state       <= n_state;
            r_sector_addr <= n_sector_addr;
            r_byte_count  <= n_byte_count;
            r_running_xor <= n_running_xor;
            r_card_flags  <= n_card_flags;
            r_prev_tx     <= n_prev_tx;
        end
    end

    assign low_latched = ((r_sector_addr & 16'hFF00) | {8'h00, i_tx_byte}) & mcsp_pkg::ADDR_MASK;

    // Read address follows the next state, so the registered read data lines up with
    // whatever byte position the following item will see.
    assign o_rd_addr = {n_sector_addr[mcsp_pkg::SEC_W-1:0], n_byte_count};

    always_comb begin
        n_state       = r_state;
        n_sector_addr = r_sector_addr;
        n_byte_count  = r_byte_count;
        n_running_xor = r_running_xor;
        n_card_flags  = r_card_flags;
        n_prev_tx     = r_prev_tx;
        o_wr.en       = 1'b0;
        o_wr.addr     = {r_sector_addr[mcsp_pkg::SEC_W-1:0], r_byte_count};
        o_wr.data     = i_tx_byte;
        o_result.rx_byte = mcsp_pkg::BYTE_IDLE;
        o_result.ack     = 1'b1;

        if (i_kind) begin
            o_result.ack = 1'b0;
            if (i_fire) begin
                n_state = mcsp_pkg::ST_IDLE;
            end
        end else begin
            case (r_state)
                mcsp_pkg::ST_IDLE: begin
                    if (i_tx_byte == mcsp_pkg::BYTE_SELECT) begin
                        n_state = mcsp_pkg::ST_CMD;
                    end else begin
                        o_result.ack = 1'b0;
                    end
                end
                mcsp_pkg::ST_CMD: begin
                    o_result.rx_byte = r_card_flags;
                    if (i_tx_byte == mcsp_pkg::BYTE_READ) begin
                        n_state = mcsp_pkg::ST_R_ID1;
                    end else if (i_tx_byte == mcsp_pkg::BYTE_WRITE) begin
                        n_state = mcsp_pkg::ST_W_ID1;
                    end else begin
                        n_state      = mcsp_pkg::ST_IDLE;
                        o_result.ack = 1'b0;
                    end
                end
                mcsp_pkg::ST_R_ID1: begin
                    o_result.rx_byte = mcsp_pkg::BYTE_ID1;
                    n_state = mcsp_pkg::ST_R_ID2;
                end
                mcsp_pkg::ST_R_ID2: begin
                    o_result.rx_byte = mcsp_pkg::BYTE_ID2;
                    n_state = mcsp_pkg::ST_R_A1;
                end
                mcsp_pkg::ST_R_A1, mcsp_pkg::ST_W_A1: begin
                    o_result.rx_byte = 8'h00;
                    n_sector_addr = {i_tx_byte, 8'h00};
                    n_state = (r_state == mcsp_pkg::ST_R_A1) ? mcsp_pkg::ST_R_A2
                                                             : mcsp_pkg::ST_W_A2;
                end
                mcsp_pkg::ST_R_A2, mcsp_pkg::ST_W_A2: begin
                    o_result.rx_byte = r_sector_addr[15:8];
                    n_sector_addr = low_latched;
                    n_byte_count  = '0;
                    n_running_xor = low_latched[15:8] ^ low_latched[7:0];
                    n_state = (r_state == mcsp_pkg::ST_R_A2) ? mcsp_pkg::ST_R_ACK1
                                                             : mcsp_pkg::ST_W_DATA;
                end
                mcsp_pkg::ST_R_ACK1: begin
                    o_result.rx_byte = mcsp_pkg::BYTE_CMD_ACK;
                    n_state = mcsp_pkg::ST_R_ACK2;
                end
                mcsp_pkg::ST_R_ACK2: begin
                    o_result.rx_byte = mcsp_pkg::BYTE_ID2;
                    n_state = mcsp_pkg::ST_R_CA1;
                end
                mcsp_pkg::ST_R_CA1: begin
                    o_result.rx_byte = r_sector_addr[15:8];
                    n_state = mcsp_pkg::ST_R_CA2;
                end
                mcsp_pkg::ST_R_CA2: begin
                    o_result.rx_byte = r_sector_addr[7:0];
                    n_state = mcsp_pkg::ST_R_DATA;
                end
                mcsp_pkg::ST_R_DATA: begin
                    o_result.rx_byte = i_rd_data;
                    n_running_xor = r_running_xor ^ i_rd_data;
                    if (r_byte_count < mcsp_pkg::LAST_BYTE) begin
                        n_byte_count = r_byte_count + 1'b1;
                    end else begin
                        n_state = mcsp_pkg::ST_R_CHK;
                    end
                end
                mcsp_pkg::ST_R_CHK: begin
                    o_result.rx_byte = r_running_xor;
                    n_state = mcsp_pkg::ST_R_END;
                end
                mcsp_pkg::ST_R_END, mcsp_pkg::ST_W_END: begin
                    o_result.rx_byte = mcsp_pkg::BYTE_END;
                    o_result.ack     = 1'b0;
                    n_state = mcsp_pkg::ST_IDLE;
                end
                mcsp_pkg::ST_W_ID1: begin
                    o_result.rx_byte = mcsp_pkg::BYTE_ID1;
                    n_state = mcsp_pkg::ST_W_ID2;
                end
                mcsp_pkg::ST_W_ID2: begin
                    o_result.rx_byte = mcsp_pkg::BYTE_ID2;
                    n_state = mcsp_pkg::ST_W_A1;
                end
                mcsp_pkg::ST_W_DATA: begin
                    o_result.rx_byte = r_prev_tx;
                    n_card_flags  = r_card_flags & mcsp_pkg::FLAGS_WRMASK;
                    o_wr.en       = i_fire;
                    n_running_xor = r_running_xor ^ i_tx_byte;
                    if (r_byte_count < mcsp_pkg::LAST_BYTE) begin
                        n_byte_count = r_byte_count + 1'b1;
                    end else begin
                        n_state = mcsp_pkg::ST_W_CHK;
                    end
                end
                mcsp_pkg::ST_W_CHK: begin
                    o_result.rx_byte = r_running_xor;
                    n_state = mcsp_pkg::ST_W_ACK1;
                end
                mcsp_pkg::ST_W_ACK1: begin
                    o_result.rx_byte = mcsp_pkg::BYTE_CMD_ACK;
                    n_state = mcsp_pkg::ST_W_ACK2;
                end
                mcsp_pkg::ST_W_ACK2: begin
                    o_result.rx_byte = mcsp_pkg::BYTE_ID2;
                    n_state = mcsp_pkg::ST_W_END;
                end
                default: begin
                    n_state      = mcsp_pkg::ST_IDLE;
                    o_result.ack = 1'b0;
                end
            endcase
            n_prev_tx = i_tx_byte;

            // Nothing moves unless an item is actually processed this cycle.
            if (!i_fire) begin
                n_state       = r_state;
                n_sector_addr = r_sector_addr;
                n_byte_count  = r_byte_count;
                n_running_xor = r_running_xor;
                n_card_flags  = r_card_flags;
                n_prev_tx     = r_prev_tx;
            end
        end
    end

endmodule

### sv/memory_card_serial_protocol.sv
// Top level of the memory card serial protocol block: stream ports, store clear, card store.
//
//   channel  | dir | signals                          | payload
//   ---------+-----+----------------------------------+------------------------------------
//   s (host) | in  | i_s_tvalid o_s_tready            | tuser: kind; tdata[7:0]: tx_byte
//   m (card) | out | o_m_tvalid i_m_tready            | tdata[7:0]: rx_byte, [8]: ack
//
// One item per cycle sustained while the card side is ready and no clear runs: an input
// register feeds the sequencer, whose reply is written to the output register; the card
// store read is prefetched from the next state, so data bytes need no wait on the store.
// After reset the card store's 131072 bytes are zeroed one byte per cycle, with o_s_tready
// low meanwhile. A stalled output holds its reply; the input register keeps taking items
// as long as the reply it is about to produce has a free slot.
module memory_card_serial_protocol (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] tx_byte
    input  logic        i_s_tuser,   // [0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [7:0] rx_byte, [8] ack, [15:9] zero
);

    logic                        r_in_valid;
    logic                        r_kind;
    logic [7:0]                  r_tx;
    logic                        r_out_valid;
    mcsp_pkg::t_result           r_result;
    logic                        r_clearing;
    logic [mcsp_pkg::ADDR_W-1:0] r_clr_addr;

    logic                        fire;
    logic                        s_ready;
    logic [mcsp_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  rd_data;
    mcsp_pkg::t_ram_wr           fsm_wr;
    mcsp_pkg::t_ram_wr           ram_wr;
    mcsp_pkg::t_result           result;

    assign fire    = r_in_valid && (!r_out_valid || i_m_tready);
    assign s_ready = !r_clearing && (!r_in_valid || fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && s_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && s_ready) begin
            r_kind <= i_s_tuser;
            r_tx   <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    mcsp_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_kind    (r_kind),
        .i_tx_byte (r_tx),
        .i_rd_data (rd_data),
        .o_rd_addr (rd_addr),
        .o_wr      (fsm_wr),
        .o_result  (result)
    );

    always_comb begin
        if (r_clearing) begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = r_clr_addr;
            ram_wr.data = 8'h00;
        end else begin
            ram_wr = fsm_wr;
        end
    end

    mcsp_ram #(
        .WIDTH (8),
        .DEPTH (mcsp_pkg::STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_wr.en),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_result.ack, r_result.rx_byte};

endmodule
